FILE: sv/rhsv_pkg.sv
// shared widths, latencies and types for the rgb to hsv pipeline
// no dependencies; imported by every module of the block
package rhsv_pkg;

  localparam int PIX_W     = 8;   // channel width
  localparam int Q_W       = 8;   // quotient width of both dividers
  localparam int TOT_W     = 11;  // hue numerator before scaling, below 6*255
  localparam int SAT_NUM_W = 16;  // 255*d
  localparam int SAT_DEN_W = 8;   // max
  localparam int HUE_NUM_W = 19;  // 255*total
  localparam int HUE_DEN_W = 11;  // 6*d
  localparam int PREP_LAT  = 3;   // register stages in front of the dividers
  localparam int LATENCY   = PREP_LAT + Q_W;

  // fields that ride alongside the arithmetic
  typedef struct packed {
    logic [PIX_W-1:0] val;
    logic [PIX_W-1:0] alpha;
  } side_t;

endpackage

FILE: sv/rhsv_prep.sv
// front end of the pipeline: max/min, sextant, hue numerator and divider operands
// depends on rhsv_pkg; feeds two rhsv_div instances
module rhsv_prep (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic [rhsv_pkg::PIX_W-1:0]       red_in,
  input  logic [rhsv_pkg::PIX_W-1:0]       green_in,
  input  logic [rhsv_pkg::PIX_W-1:0]       blue_in,
  input  logic [rhsv_pkg::PIX_W-1:0]       alpha_in,
  output logic                             out_valid,
  output rhsv_pkg::side_t                  side,
  output logic [rhsv_pkg::SAT_NUM_W-1:0]   sat_num,
  output logic [rhsv_pkg::SAT_DEN_W-1:0]   sat_den,
  output logic [rhsv_pkg::HUE_NUM_W-1:0]   hue_num,
  output logic [rhsv_pkg::HUE_DEN_W-1:0]   hue_den
);
  import rhsv_pkg::*;

  typedef enum logic [1:0] {
    SEXT_RED,
    SEXT_GREEN,
    SEXT_BLUE
  } sext_t;

  // stage 1 registers
  logic             v1;
  logic [PIX_W-1:0] mx1;
  logic [PIX_W-1:0] mn1;
  sext_t            sext1;
  logic [PIX_W:0]   num1;   // two's complement channel difference
  side_t            side1;

  // stage 2 registers
  logic             v2;
  logic [PIX_W-1:0] d2;
  logic [PIX_W-1:0] mx2;
  logic [TOT_W-1:0] tot2;
  side_t            side2;

  // stage 1 combinational
  logic             red_max;
  logic             green_max;
  logic [PIX_W-1:0] mx_next;
  logic [PIX_W-1:0] mn_next;
  sext_t            sext_next;
  logic [PIX_W:0]   num_next;

  // stage 2 combinational
  logic [PIX_W-1:0] d_next;
  logic [TOT_W-1:0] d_ext;
  logic [TOT_W-1:0] base_next;
  logic [TOT_W-1:0] tot_next;

  // sextant select, red then green then blue
  always_comb begin
    red_max   = (red_in >= green_in) && (red_in >= blue_in);
    green_max = (green_in >= blue_in);
    if (red_max) begin
      sext_next = SEXT_RED;
      mx_next   = red_in;
      num_next  = {1'b0, green_in} - {1'b0, blue_in};
    end else if (green_max) begin
      sext_next = SEXT_GREEN;
      mx_next   = green_in;
      num_next  = {1'b0, blue_in} - {1'b0, red_in};
    end else begin
      sext_next = SEXT_BLUE;
      mx_next   = blue_in;
      num_next  = {1'b0, red_in} - {1'b0, green_in};
    end
    mn_next = red_in;
    if (green_in < mn_next) begin
      mn_next = green_in;
    end
    if (blue_in < mn_next) begin
      mn_next = blue_in;
    end
  end

  // spread and offset sixths; a negative red hue wraps by a full turn
  always_comb begin
    d_next = mx1 - mn1;
    d_ext  = TOT_W'(d_next);
    case (sext1)
      SEXT_RED:   base_next = num1[PIX_W] ? ((d_ext << 2) + (d_ext << 1)) : '0;
      SEXT_GREEN: base_next = d_ext << 1;
      SEXT_BLUE:  base_next = d_ext << 2;
      default:    base_next = '0;
    endcase
    tot_next = base_next + {{(TOT_W-PIX_W-1){num1[PIX_W]}}, num1};
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  // payload, stage 1 and 2
  always_ff @(posedge clk) begin
    mx1         <= mx_next;
    mn1         <= mn_next;
    sext1       <= sext_next;
    num1        <= num_next;
    side1.val   <= mx_next;
    side1.alpha <= alpha_in;
    d2          <= d_next;
    mx2         <= mx1;
    tot2        <= tot_next;
    side2       <= side1;
  end

  // stage 3: scale by 255; grey pixels get 0 over 1 so both quotients are 0
  always_ff @(posedge clk) begin
    side <= side2;
    if (d2 == '0) begin
      sat_num <= '0;
      sat_den <= SAT_DEN_W'(1);
      hue_num <= '0;
      hue_den <= HUE_DEN_W'(1);
    end else begin
      sat_num <= {d2, 8'b0} - SAT_NUM_W'(d2);
      sat_den <= mx2;
      hue_num <= {tot2, 8'b0} - HUE_NUM_W'(tot2);
      hue_den <= (HUE_DEN_W'(d2) << 2) + (HUE_DEN_W'(d2) << 1);
    end
  end

endmodule

FILE: sv/rhsv_div.sv
// pipelined restoring divider, one quotient bit per register stage
// depends on rhsv_pkg; quotient must fit in Q_W bits
module rhsv_div #(
  parameter int NUM_W = 19,
  parameter int DEN_W = 11,
  parameter int Q_W   = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             out_valid,
  output logic [Q_W-1:0]   quo
);
  import rhsv_pkg::*;

  localparam int CMP_W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic             vld_q [Q_W+1];
  logic [NUM_W-1:0] rem_q [Q_W];
  logic [DEN_W-1:0] den_q [Q_W];
  logic [Q_W-1:0]   quo_q [Q_W+1];

  assign vld_q[0] = in_valid;
  assign rem_q[0] = num;
  assign den_q[0] = den;
  assign quo_q[0] = '0;

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    localparam int B = Q_W - 1 - k;
    logic [CMP_W-1:0] shifted;
    logic [CMP_W-1:0] rem_ext;
    logic [CMP_W-1:0] diff;
    logic             fits;

    // trial subtract of the divisor at this bit weight
    assign shifted = CMP_W'(den_q[k]) << B;
    assign rem_ext = CMP_W'(rem_q[k]);
    assign diff    = rem_ext - shifted;
    assign fits    = (rem_ext >= shifted);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk) begin
      quo_q[k+1] <= {quo_q[k][Q_W-2:0], fits};
    end

    // the last stage needs no remainder or divisor
    if (k < Q_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem_q[k+1] <= fits ? NUM_W'(diff) : rem_q[k];
        den_q[k+1] <= den_q[k];
      end
    end
  end

  assign out_valid = vld_q[Q_W];
  assign quo       = quo_q[Q_W];

endmodule

FILE: sv/rgb_to_hsv_8bit.sv
// Converts one RGBA pixel to HSVA per clock, fully pipelined. A request is
// taken whenever start is high; busy is always low. The result for each
// request appears on the cycle that done is high, and is shown for that
// one cycle only: the receiver cannot hold it. The latency (LATENCY in
// rhsv_pkg) is set by three stages of operand preparation and the two
// 8-stage restoring dividers, one quotient bit per stage, for saturation
// and hue running side by side. Requests leave in the order they came.
// depends on rhsv_pkg, rhsv_prep, rhsv_div
module rgb_to_hsv_8bit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [rhsv_pkg::PIX_W-1:0] red_in,
  input  logic [rhsv_pkg::PIX_W-1:0] green_in,
  input  logic [rhsv_pkg::PIX_W-1:0] blue_in,
  input  logic [rhsv_pkg::PIX_W-1:0] alpha_in,
  output logic                       done,
  output logic [rhsv_pkg::PIX_W-1:0] hue_out,
  output logic [rhsv_pkg::PIX_W-1:0] sat_out,
  output logic [rhsv_pkg::PIX_W-1:0] val_out,
  output logic [rhsv_pkg::PIX_W-1:0] alpha_out
);
  import rhsv_pkg::*;

  logic                 accept;
  logic                 prep_valid;
  side_t                prep_side;
  logic [SAT_NUM_W-1:0] sat_num;
  logic [SAT_DEN_W-1:0] sat_den;
  logic [HUE_NUM_W-1:0] hue_num;
  logic [HUE_DEN_W-1:0] hue_den;
  logic                 sat_valid;
  logic                 hue_valid;
  logic [Q_W-1:0]       sat_quo;
  logic [Q_W-1:0]       hue_quo;
  side_t                side_q [Q_W];

  // never stalls
  assign busy   = 1'b0;
  assign accept = start && !busy;

  rhsv_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .red_in    (red_in),
    .green_in  (green_in),
    .blue_in   (blue_in),
    .alpha_in  (alpha_in),
    .out_valid (prep_valid),
    .side      (prep_side),
    .sat_num   (sat_num),
    .sat_den   (sat_den),
    .hue_num   (hue_num),
    .hue_den   (hue_den)
  );

  rhsv_div #(
    .NUM_W (SAT_NUM_W),
    .DEN_W (SAT_DEN_W),
    .Q_W   (Q_W)
  ) u_sat_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prep_valid),
    .num       (sat_num),
    .den       (sat_den),
    .out_valid (sat_valid),
    .quo       (sat_quo)
  );

  rhsv_div #(
    .NUM_W (HUE_NUM_W),
    .DEN_W (HUE_DEN_W),
    .Q_W   (Q_W)
  ) u_hue_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prep_valid),
    .num       (hue_num),
    .den       (hue_den),
    .out_valid (hue_valid),
    .quo       (hue_quo)
  );

  // value and alpha follow the dividers
  always_ff @(posedge clk) begin
    side_q[0] <= prep_side;
    for (int i = 1; i < Q_W; i++) begin
      side_q[i] <= side_q[i-1];
    end
  end

  assign done      = sat_valid;
  assign hue_out   = hue_quo;
  assign sat_out   = sat_quo;
  assign val_out   = side_q[Q_W-1].val;
  assign alpha_out = side_q[Q_W-1].alpha;

  // both dividers stay in lock step
  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    hue_valid == sat_valid)
    else $error("hue and saturation dividers out of step");

  // every result traces back to a request a fixed latency earlier
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LATENCY))
    else $error("result without matching request");

  // black pixels carry no hue or saturation
  a_black: assert property (@(posedge clk) disable iff (rst)
    (done && val_out == '0) |-> (hue_out == '0 && sat_out == '0))
    else $error("black pixel with nonzero hue or saturation");

  // hue output stays below a full turn
  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    done |-> hue_out != 8'hff)
    else $error("hue reached a full turn");

endmodule

FILE: tb/rgb_to_hsv_8bit_test.sv
// self-checking testbench for the rgb_to_hsv_8bit pixel converter
// depends on rhsv_pkg and rgb_to_hsv_8bit; predicts each hsva result and checks it in order
`timescale 1ns / 100ps

module rgb_to_hsv_8bit_test;
  import rhsv_pkg::*;

  localparam int PIXEL_COUNT    = 900;
  localparam int PAUSE_AFTER    = PIXEL_COUNT / 2;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct {
    logic [PIX_W-1:0] hue;
    logic [PIX_W-1:0] sat;
    logic [PIX_W-1:0] val;
    logic [PIX_W-1:0] alpha;
  } hsv_pixel_t;

  // expected hsva pixels in request order, plus the mismatch tally
  class hsv_ledger;
    hsv_pixel_t pending_hsv[$];
    int         mismatches;

    function new();
      mismatches = 0;
    endfunction

    // integer hsv conversion, hue sextant priority red, green, blue
    function hsv_pixel_t rgb_hsv_predict(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                                         logic [PIX_W-1:0] b, logic [PIX_W-1:0] a);
      hsv_pixel_t p;
      int ri;
      int gi;
      int bi;
      int hi;
      int lo;
      int spread;
      int turn;
      ri = int'(r);
      gi = int'(g);
      bi = int'(b);
      hi = (ri > gi) ? ri : gi;
      hi = (hi > bi) ? hi : bi;
      lo = (ri < gi) ? ri : gi;
      lo = (lo < bi) ? lo : bi;
      spread = hi - lo;
      p.hue = '0;
      p.sat = '0;
      p.val = hi[PIX_W-1:0];
      p.alpha = a;
      if (hi != 0 && spread != 0) begin
        p.sat = PIX_W'((255 * spread) / hi);
        if (hi == ri) begin
          // negative red hue wraps by a full turn
          turn = (gi >= bi) ? (gi - bi) : (6 * spread - (bi - gi));
        end else if (hi == gi) begin
          turn = 2 * spread + bi - ri;
        end else begin
          turn = 4 * spread + ri - gi;
        end
        p.hue = PIX_W'((255 * turn) / (6 * spread));
      end
      return p;
    endfunction

    function void note_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                             logic [PIX_W-1:0] b, logic [PIX_W-1:0] a);
      pending_hsv.push_back(rgb_hsv_predict(r, g, b, a));
    endfunction

    function int pending();
      return pending_hsv.size();
    endfunction

    function void compare_field(string field, logic [PIX_W-1:0] want,
                                logic [PIX_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        mismatches++;
      end
    endfunction

    function void check_pixel(logic [PIX_W-1:0] h, logic [PIX_W-1:0] s,
                              logic [PIX_W-1:0] v, logic [PIX_W-1:0] a);
      hsv_pixel_t want;
      if (pending_hsv.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual h=%0d s=%0d v=%0d a=%0d",
                 $time, h, s, v, a);
        mismatches++;
        return;
      end
      want = pending_hsv.pop_front();
      compare_field("hue", want.hue, h);
      compare_field("sat", want.sat, s);
      compare_field("val", want.val, v);
      compare_field("alpha", want.alpha, a);
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  logic [PIX_W-1:0] red_in;
  logic [PIX_W-1:0] green_in;
  logic [PIX_W-1:0] blue_in;
  logic [PIX_W-1:0] alpha_in;
  logic             done;
  logic [PIX_W-1:0] hue_out;
  logic [PIX_W-1:0] sat_out;
  logic [PIX_W-1:0] val_out;
  logic [PIX_W-1:0] alpha_out;

  hsv_ledger ledger = new();
  int        idle_cycles;

  rgb_to_hsv_8bit dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .red_in    (red_in),
    .green_in  (green_in),
    .blue_in   (blue_in),
    .alpha_in  (alpha_in),
    .done      (done),
    .hue_out   (hue_out),
    .sat_out   (sat_out),
    .val_out   (val_out),
    .alpha_out (alpha_out)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result checking and watchdog on cycles with no traffic
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (done === 1'b1)
        ledger.check_pixel(hue_out, sat_out, val_out, alpha_out);
      if ((start === 1'b1 && busy === 1'b0) || done === 1'b1) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // present one request and hold it until it is taken
  task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                            input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] a);
    start    <= 1'b1;
    red_in   <= r;
    green_in <= g;
    blue_in  <= b;
    alpha_in <= a;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    ledger.note_pixel(r, g, b, a);
  endtask

  // drop start for the given number of clocks, optionally until every result is back
  task automatic idle_gap(input int cycles, input bit drain);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
    if (drain)
      while (ledger.pending() != 0) @(posedge clk);
  endtask

  // random pixel, weighted toward ties, greys, small spreads and corner values
  task automatic send_random_pixel();
    logic [PIX_W-1:0] r;
    logic [PIX_W-1:0] g;
    logic [PIX_W-1:0] b;
    logic [PIX_W-1:0] a;
    logic [PIX_W-1:0] base;
    logic [PIX_W-1:0] corners[4];
    corners = '{8'd0, 8'd1, 8'd254, 8'd255};
    r = PIX_W'($urandom);
    g = PIX_W'($urandom);
    b = PIX_W'($urandom);
    a = PIX_W'($urandom);
    case ($urandom_range(0, 9))
      6: begin
        // two channels tied at the top
        base = PIX_W'($urandom);
        case ($urandom_range(0, 2))
          0: begin r = base; g = base; b = PIX_W'($urandom_range(0, base)); end
          1: begin g = base; b = base; r = PIX_W'($urandom_range(0, base)); end
          default: begin r = base; b = base; g = PIX_W'($urandom_range(0, base)); end
        endcase
      end
      7: begin
        g = r;
        b = r;
      end
      8: begin
        // near grey, spread of a few counts
        base = PIX_W'($urandom_range(0, 251));
        r = base + PIX_W'($urandom_range(0, 4));
        g = base + PIX_W'($urandom_range(0, 4));
        b = base + PIX_W'($urandom_range(0, 4));
      end
      9: begin
        r = corners[$urandom_range(0, 3)];
        g = corners[$urandom_range(0, 3)];
        b = corners[$urandom_range(0, 3)];
      end
      default: ;
    endcase
    send_pixel(r, g, b, a);
  endtask

  // stimulus
  initial begin
    int sent;
    int burst;
    bit paused;
    rst      <= 1'b1;
    start    <= 1'b0;
    red_in   <= '0;
    green_in <= '0;
    blue_in  <= '0;
    alpha_in <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // black, white and grey
    send_pixel(8'd0,   8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128, 8'h55);
    // pure primaries
    send_pixel(8'd255, 8'd0,   8'd0,   8'hAA);
    send_pixel(8'd0,   8'd255, 8'd0,   8'd255);
    send_pixel(8'd0,   8'd0,   8'd255, 8'd0);
    // red sextant, green above and below blue (wrap)
    send_pixel(8'd255, 8'd10,  8'd5,   8'd1);
    send_pixel(8'd255, 8'd0,   8'd1,   8'd254);
    // green and blue sextants
    send_pixel(8'd10,  8'd200, 8'd50,  8'd17);
    send_pixel(8'd50,  8'd10,  8'd200, 8'd240);
    // ties at the maximum decide by priority
    send_pixel(8'd200, 8'd200, 8'd10,  8'd3);
    send_pixel(8'd10,  8'd200, 8'd200, 8'd99);
    send_pixel(8'd200, 8'd10,  8'd200, 8'd128);
    // smallest spreads, smallest nonzero maximum and a near tie at the top
    send_pixel(8'd255, 8'd254, 8'd254, 8'd127);
    send_pixel(8'd1,   8'd0,   8'd0,   8'd255);
    send_pixel(8'd0,   8'd1,   8'd0,   8'd0);
    send_pixel(8'd0,   8'd0,   8'd1,   8'h0F);
    send_pixel(8'd254, 8'd255, 8'd0,   8'hF0);
    idle_gap(1, 1'b1);

    // random bursts with random gaps
    sent = 0;
    paused = 1'b0;
    while (sent < PIXEL_COUNT) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && sent < PIXEL_COUNT; i++) begin
        send_random_pixel();
        sent++;
      end
      if (!paused && sent >= PAUSE_AFTER) begin
        paused = 1'b1;
        idle_gap($urandom_range(1, 12), 1'b1);
      end else begin
        idle_gap($urandom_range(1, 12), 1'b0);
      end
    end

    // drain, then let the pipeline settle
    while (ledger.pending() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
    if (ledger.mismatches == 0 && ledger.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
